// File: hw/rtl/csi_pkg.sv
// Shared types and constants for the cubic spline sample interpolator.
package csi_pkg;

  // Fixed field and state widths.
  localparam int SAMPLE_W = 16;
  localparam int POS_W    = 16;
  localparam int SLOPE_W  = 18;
  localparam int COEF_W   = 22;
  localparam int OUT_W    = 18;
  localparam int SUM_W    = 26;
  localparam int CHUNK_W  = 32;

  // Saturation bounds of the result, at the width of the final sum.
  localparam logic signed [SUM_W-1:0] SAT_MAX = SUM_W'(131071);
  localparam logic signed [SUM_W-1:0] SAT_MIN = -SUM_W'(131072);

  // Command codes of an input item.
  localparam logic CMD_ADVANCE  = 1'b0;
  localparam logic CMD_EVALUATE = 1'b1;

  // Operations of the shared multiply-accumulate unit.
  typedef enum logic [1:0] {
    MAC_HOLD,
    MAC_LOAD,
    MAC_STEP
  } mac_op_t;

  // Status that the multiply-accumulate unit reports to the sequencer.
  typedef struct packed {
    logic last_chunk;
  } mac_status_t;

endpackage

// File: hw/rtl/csi_coef.sv
// Segment coefficient calculation for an advance item.
module csi_coef
  import csi_pkg::*;
#(
  parameter int SAMPLE_BITS = 16
) (
  input  logic        [SAMPLE_W-1:0] seg_start,
  input  logic        [SAMPLE_W-1:0] seg_end,
  input  logic        [SAMPLE_W-1:0] next_s,
  input  logic signed [SLOPE_W-1:0]  slope_old,
  output logic signed [SAMPLE_W-1:0] start_val,
  output logic signed [SLOPE_W-1:0]  slope_new,
  output logic signed [COEF_W-1:0]   coef_cubic,
  output logic signed [COEF_W-1:0]   coef_square,
  output logic signed [COEF_W-1:0]   coef_linear
);

  logic signed [COEF_W-1:0] s1, s2, s3, d, sn, so;

  // Sign-extend the used sample bits, then form the Q1 slopes and coefficients.
  always_comb begin
    s1 = COEF_W'($signed(seg_start[SAMPLE_BITS-1:0]));
    s2 = COEF_W'($signed(seg_end[SAMPLE_BITS-1:0]));
    s3 = COEF_W'($signed(next_s[SAMPLE_BITS-1:0]));
    d  = s2 - s1;
    sn = s3 - s1;
    so = COEF_W'(slope_old);
    coef_linear = so;
    coef_square = (d <<< 2) + (d <<< 1) - sn - (so <<< 1);
    coef_cubic  = sn + so - (d <<< 2);
    slope_new   = sn[SLOPE_W-1:0];
    start_val   = s1[SAMPLE_W-1:0];
  end

endmodule

// File: hw/rtl/csi_mac.sv
// Shared chunked multiply-accumulate unit for the Horner evaluation.
module csi_mac
  import csi_pkg::*;
#(
  parameter int AW  = 70,
  parameter int TW  = 15,
  parameter int NCH = 3
) (
  input  logic          clk,
  input  logic          rst_n,
  input  mac_op_t       op,
  input  logic [AW-1:0] load_val,
  input  logic [AW-1:0] init_val,
  input  logic [TW-1:0] t,
  output logic [AW-1:0] acc,
  output mac_status_t   status
);

  localparam int KW = (NCH > 1) ? $clog2(NCH) : 1;

  logic [KW-1:0]          k_r;
  logic [AW-1:0]          acc_r;
  logic [AW-1:0]          res_r;
  logic [NCH*CHUNK_W-1:0] acc_pad;
  logic [CHUNK_W-1:0]     chunk;
  logic [CHUNK_W+TW-1:0]  prod;
  logic [AW-1:0]          part;
  logic [AW-1:0]          sum;
  logic                   last;

  // One 32-bit chunk of the multiplicand times t per cycle while op is MAC_STEP, placed at its weight.
  // The sum wraps modulo 2^AW, which keeps the two's complement product exact.
  always_comb begin
    acc_pad = (NCH*CHUNK_W)'(acc_r);
    chunk   = acc_pad[k_r*CHUNK_W +: CHUNK_W];
    prod    = (CHUNK_W+TW)'(chunk) * (CHUNK_W+TW)'(t);
    part    = AW'(prod) << (CHUNK_W * int'(k_r));
    sum     = res_r + part;
    last    = (k_r == KW'(NCH-1));
  end

  // On the last chunk the product becomes the next multiplicand and the
  // accumulator takes the next Horner term.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      k_r <= '0;
    end else begin
      unique case (op)
        MAC_LOAD: begin
          acc_r <= load_val;
          res_r <= init_val;
          k_r   <= '0;
        end
        MAC_STEP: begin
          if (last) begin
            acc_r <= sum;
            res_r <= init_val;
            k_r   <= '0;
          end else begin
            res_r <= sum;
            k_r   <= k_r + KW'(1);
          end
        end
        MAC_HOLD: begin
        end
        default: begin
        end
      endcase
    end
  end

  assign acc               = acc_r;
  assign status.last_chunk = last;

endmodule

// File: hw/rtl/csi_round.sv
// Round to nearest even, add the segment start and saturate to the result width.
module csi_round
  import csi_pkg::*;
#(
  parameter int AW = 70,
  parameter int S  = 46
) (
  input  logic        [AW-1:0]       acc,
  input  logic signed [SAMPLE_W-1:0] start_val,
  output logic signed [OUT_W-1:0]    value
);

  logic                    half, low, inc;
  logic signed [SUM_W-1:0] q, sum;

  always_comb begin
    q    = SUM_W'($signed(acc[AW-1:S]));
    half = acc[S-1];
    low  = |acc[S-2:0];
    inc  = half & (low | q[0]);
    sum  = q + SUM_W'(inc) + SUM_W'(start_val);
    // Clamp to the nearest bound when the sum leaves the result range.
    priority if (sum > SAT_MAX) begin
      value = SAT_MAX[OUT_W-1:0];
    end else if (sum < SAT_MIN) begin
      value = SAT_MIN[OUT_W-1:0];
    end else begin
      value = sum[OUT_W-1:0];
    end
  end

endmodule

// File: hw/rtl/cubic_spline_sample_interpolator.sv
// Top level of the Catmull-Rom cubic spline sample interpolator.
//
//   Channel  | Ports                                              | Direction
//   ---------+----------------------------------------------------+----------
//   in_      | valid, stall, command, seg_start_sample,           | input
//            | seg_end_sample, next_sample, frac_position         |
//   out_     | valid, stall, interp_value                         | output
//
// An advance item loads the segment registers as it is accepted; no result.
// An evaluate item loads the cubic coefficient into the multiply-accumulate
// unit when accepted, then runs three Horner steps, each passing NCH = ceil(AW/32)
// chunks of the Horner accumulator through the one shared 32-bit by t
// multiplier; its result is registered once the output register can take it.
// The input is stalled while an evaluation runs, and a finished result waits
// in the output register while a new item is accepted.
// Reset is synchronous and active low; it clears the segment state to zero.
module cubic_spline_sample_interpolator
  import csi_pkg::*;
#(
  parameter int FRAC_BITS   = 16,
  parameter int SAMPLE_BITS = 16
) (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    in_valid,
  output logic                    in_stall,
  input  logic                    in_command,
  input  logic signed [SAMPLE_W-1:0] in_seg_start_sample,
  input  logic signed [SAMPLE_W-1:0] in_seg_end_sample,
  input  logic signed [SAMPLE_W-1:0] in_next_sample,
  input  logic        [POS_W-1:0] in_frac_position,
  output logic                    out_valid,
  input  logic                    out_stall,
  output logic signed [OUT_W-1:0] out_interp_value
);

  localparam int F   = FRAC_BITS - 1;
  localparam int FB  = (FRAC_BITS > POS_W) ? POS_W : FRAC_BITS;
  localparam int TW  = FB - 1;
  localparam int AW  = 25 + 2*F + TW;
  localparam int NCH = (AW + CHUNK_W - 1) / CHUNK_W;
  localparam int S   = 3*F + 1;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_MUL,
    ST_ROUND
  } state_t;

  state_t                   state_r, state_nxt;
  logic [1:0]               pass_r;
  logic [TW-1:0]            t_r;
  logic signed [SAMPLE_W-1:0] start_r;
  logic signed [SLOPE_W-1:0]  slope_r;
  logic signed [COEF_W-1:0]   cubic_r, square_r, linear_r;
  logic                     out_valid_r;
  logic signed [OUT_W-1:0]  out_value_r;

  logic                     accept, take_out;
  logic signed [SAMPLE_W-1:0] start_new;
  logic signed [SLOPE_W-1:0]  slope_new;
  logic signed [COEF_W-1:0]   cubic_new, square_new, linear_new;
  mac_op_t                  mac_op;
  mac_status_t              mac_st;
  logic [AW-1:0]            load_val, init_val, acc;
  logic signed [OUT_W-1:0]  round_val;

  assign accept   = in_valid && !in_stall;
  assign in_stall = (state_r != ST_IDLE);
  assign take_out = !out_valid_r || !out_stall;

  csi_coef #(
    .SAMPLE_BITS(SAMPLE_BITS)
  ) u_coef (
    .seg_start  (in_seg_start_sample),
    .seg_end    (in_seg_end_sample),
    .next_s     (in_next_sample),
    .slope_old  (slope_r),
    .start_val  (start_new),
    .slope_new  (slope_new),
    .coef_cubic (cubic_new),
    .coef_square(square_new),
    .coef_linear(linear_new)
  );

  // Sequencer: load the cubic coefficient, run three Horner passes, then round.
  always_comb begin
    state_nxt = state_r;
    mac_op    = MAC_HOLD;
    load_val  = AW'(cubic_r);
    init_val  = AW'(square_r) <<< F;
    unique case (state_r)
      ST_IDLE: begin
        if (accept && in_command == CMD_EVALUATE) begin
          mac_op    = MAC_LOAD;
          state_nxt = ST_MUL;
        end
      end
      ST_MUL: begin
        mac_op   = MAC_STEP;
        init_val = (pass_r == 2'd0) ? (AW'(linear_r) <<< (2*F)) : '0;
        if (mac_st.last_chunk && pass_r == 2'd2) begin
          state_nxt = ST_ROUND;
        end
      end
      ST_ROUND: begin
        if (take_out) begin
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  csi_mac #(
    .AW (AW),
    .TW (TW),
    .NCH(NCH)
  ) u_mac (
    .clk     (clk),
    .rst_n   (rst_n),
    .op      (mac_op),
    .load_val(load_val),
    .init_val(init_val),
    .t       (t_r),
    .acc     (acc),
    .status  (mac_st)
  );

  csi_round #(
    .AW(AW),
    .S (S)
  ) u_round (
    .acc      (acc),
    .start_val(start_r),
    .value    (round_val)
  );

  // State, segment registers and the output register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      pass_r      <= '0;
      start_r     <= '0;
      slope_r     <= '0;
      cubic_r     <= '0;
      square_r    <= '0;
      linear_r    <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      // In the round state a taken result is replaced by the new one below.
      if (out_valid_r && !out_stall && state_r != ST_ROUND) begin
        out_valid_r <= 1'b0;
      end
      unique case (state_r)
        ST_IDLE: begin
          pass_r <= '0;
          if (accept) begin
            if (in_command == CMD_ADVANCE) begin
              start_r  <= start_new;
              slope_r  <= slope_new;
              cubic_r  <= cubic_new;
              square_r <= square_new;
              linear_r <= linear_new;
            end else begin
              t_r <= in_frac_position[FB-1:1];
            end
          end
        end
        ST_MUL: begin
          if (mac_st.last_chunk) begin
            pass_r <= pass_r + 2'd1;
          end
        end
        ST_ROUND: begin
          if (take_out) begin
            out_valid_r <= 1'b1;
            out_value_r <= round_val;
          end
        end
        default: begin
        end
      endcase
    end
  end

  assign out_valid        = out_valid_r;
  assign out_interp_value = out_value_r;

endmodule

// File: verif/tb_cubic_spline_sample_interpolator.sv
// Self-checking testbench for the cubic spline sample interpolator.
module tb_cubic_spline_sample_interpolator;
  import csi_pkg::*;

  localparam int FRAC_F      = 15;           // t is in Q15 at FRAC_BITS = 16
  localparam int ROUND_SHIFT = 3 * FRAC_F + 1;
  localparam int CYCLE_LIMIT = 300000;
  localparam int DRAIN_CYCLES = 40;
  localparam int PHASE_ITEMS = 325;

  // One input item together with the idling that applies while it is sent.
  typedef struct {
    logic                       cmd;
    logic signed [SAMPLE_W-1:0] s_start;
    logic signed [SAMPLE_W-1:0] s_end;
    logic signed [SAMPLE_W-1:0] s_next;
    logic        [POS_W-1:0]    pos;
    int                         tx_idle_pct;
    int                         rx_stall_pct;
  } sample_item_t;

  logic                       clk;
  logic                       rst_n;
  logic                       in_valid;
  logic                       in_stall;
  logic                       in_command;
  logic signed [SAMPLE_W-1:0] in_seg_start_sample;
  logic signed [SAMPLE_W-1:0] in_seg_end_sample;
  logic signed [SAMPLE_W-1:0] in_next_sample;
  logic        [POS_W-1:0]    in_frac_position;
  logic                       out_valid;
  logic                       out_stall;
  logic signed [OUT_W-1:0]    out_interp_value;

  cubic_spline_sample_interpolator uut (
    .clk                 (clk),
    .rst_n               (rst_n),
    .in_valid            (in_valid),
    .in_stall            (in_stall),
    .in_command          (in_command),
    .in_seg_start_sample (in_seg_start_sample),
    .in_seg_end_sample   (in_seg_end_sample),
    .in_next_sample      (in_next_sample),
    .in_frac_position    (in_frac_position),
    .out_valid           (out_valid),
    .out_stall           (out_stall),
    .out_interp_value    (out_interp_value)
  );

  // Items waiting to be sent and interpolated values waiting to come out.
  sample_item_t            pending_items[$];
  logic signed [OUT_W-1:0] expected_values[$];

  // Segment state of the predictor.
  logic signed [SAMPLE_W-1:0] seg_start_q;
  logic signed [SLOPE_W-1:0]  carried_slope_q;
  logic signed [COEF_W-1:0]   cubic_q;
  logic signed [COEF_W-1:0]   square_q;
  logic signed [COEF_W-1:0]   linear_q;

  int  rx_stall_pct;
  int  cycle_cnt;
  int  n_errors;
  int  n_advances;
  int  n_evaluates;
  int  n_checked;
  bit  in_taken;
  logic signed [OUT_W-1:0] want_value;

  // Loading a new segment: Catmull-Rom end slope, carried start slope.
  function automatic void segment_advance(logic signed [SAMPLE_W-1:0] s0,
                                          logic signed [SAMPLE_W-1:0] s1,
                                          logic signed [SAMPLE_W-1:0] s2);
    int a, b, c, d, sn, so;
    a  = s0;
    b  = s1;
    c  = s2;
    d  = b - a;
    sn = c - a;
    so = carried_slope_q;
    linear_q        = COEF_W'(so);
    square_q        = COEF_W'(6 * d - sn - 2 * so);
    cubic_q         = COEF_W'(sn + so - 4 * d);
    carried_slope_q = SLOPE_W'(sn);
    seg_start_q     = s0;
  endfunction

  // Horner evaluation in exact wide arithmetic, one round to nearest even,
  // then the start sample is added and the sum saturated to 18 bits.
  function automatic logic signed [OUT_W-1:0] spline_value(logic [POS_W-1:0] pos);
    logic [FRAC_F-1:0]   t;
    logic signed [127:0] tw, acc, wsq, wlin, q, v;
    logic                half, low;
    t    = pos[POS_W-1:1];
    tw   = t;
    acc  = cubic_q;
    wsq  = square_q;
    wlin = linear_q;
    acc  = acc * tw + (wsq <<< FRAC_F);
    acc  = acc * tw + (wlin <<< (2 * FRAC_F));
    acc  = acc * tw;
    q    = acc >>> ROUND_SHIFT;
    half = acc[ROUND_SHIFT-1];
    low  = |acc[ROUND_SHIFT-2:0];
    if (half && (low || q[0])) begin
      q = q + 1;
    end
    v = q + seg_start_q;
    if (v > 131071) begin
      v = 131071;
    end
    if (v < -131072) begin
      v = -131072;
    end
    return v[OUT_W-1:0];
  endfunction

  function automatic void add_item(logic cmd, logic signed [SAMPLE_W-1:0] s0,
                                   logic signed [SAMPLE_W-1:0] s1,
                                   logic signed [SAMPLE_W-1:0] s2,
                                   logic [POS_W-1:0] pos, int tx, int rx);
    sample_item_t it;
    it.cmd          = cmd;
    it.s_start      = s0;
    it.s_end        = s1;
    it.s_next       = s2;
    it.pos          = pos;
    it.tx_idle_pct  = tx;
    it.rx_stall_pct = rx;
    pending_items.push_back(it);
  endfunction

  // Random sample with a bias toward the two extremes.
  function automatic logic signed [SAMPLE_W-1:0] rand_sample();
    case ($urandom_range(7))
      0: return 16'sh7FFF;
      1: return 16'sh8000;
      default: return SAMPLE_W'($urandom);
    endcase
  endfunction

  // Random position with a bias toward both ends of the segment.
  function automatic logic [POS_W-1:0] rand_pos();
    case ($urandom_range(9))
      0: return 16'h0000;
      1: return 16'hFFFF;
      2: return 16'h0001;
      default: return POS_W'($urandom);
    endcase
  endfunction

  // Clock.
  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // Timeout guard.
  always @(posedge clk) begin
    cycle_cnt++;
    if (cycle_cnt > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles", cycle_cnt);
      $display("end of test: mismatches");
      $finish;
    end
  end

  // Input side: an item counts as taken at the edge where valid meets no stall.
  always @(posedge clk) begin
    if (rst_n && in_valid && !in_stall) begin
      in_taken = 1'b1;
      if (in_command == CMD_ADVANCE) begin
        n_advances++;
        segment_advance(in_seg_start_sample, in_seg_end_sample, in_next_sample);
      end else begin
        n_evaluates++;
        expected_values.push_back(spline_value(in_frac_position));
      end
    end
  end

  // Driver: presents the next pending item, or idles, at the falling edge.
  always @(negedge clk) begin
    if (rst_n && (!in_valid || in_taken)) begin
      in_taken = 1'b0;
      if (pending_items.size() != 0 &&
          $urandom_range(99) >= pending_items[0].tx_idle_pct) begin
        sample_item_t it;
        it = pending_items.pop_front();
        in_command          <= it.cmd;
        in_seg_start_sample <= it.s_start;
        in_seg_end_sample   <= it.s_end;
        in_next_sample      <= it.s_next;
        in_frac_position    <= it.pos;
        rx_stall_pct        <= it.rx_stall_pct;
        in_valid            <= 1'b1;
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // Receiver stall, drawn anew at each falling edge.
  always @(negedge clk) begin
    if (rst_n) begin
      out_stall <= ($urandom_range(99) < rx_stall_pct);
    end
  end

  // Monitor: compares each accepted result with the oldest expectation.
  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) begin
      if (expected_values.size() == 0) begin
        n_errors++;
        if (n_errors <= 10) begin
          $display("unexpected result: interp_value %0d", out_interp_value);
        end
      end else begin
        want_value = expected_values.pop_front();
        n_checked++;
        if (out_interp_value !== want_value) begin
          n_errors++;
          if (n_errors <= 10) begin
            $display("mismatch on result %0d: interp_value expected %0d, got %0d",
                     n_checked, want_value, out_interp_value);
          end
        end
      end
    end
  end

  // Stimulus, reset and end of run.
  initial begin
    int ph, cnt, k, nev, tx, rx;
    rst_n               = 1'b0;
    in_valid            = 1'b0;
    in_command          = CMD_ADVANCE;
    in_seg_start_sample = '0;
    in_seg_end_sample   = '0;
    in_next_sample      = '0;
    in_frac_position    = '0;
    out_stall           = 1'b0;
    rx_stall_pct        = 0;
    cycle_cnt           = 0;
    n_errors            = 0;
    n_advances          = 0;
    n_evaluates         = 0;
    n_checked           = 0;
    in_taken            = 1'b0;
    seg_start_q         = '0;
    carried_slope_q     = '0;
    cubic_q             = '0;
    square_q            = '0;
    linear_q            = '0;

    // Directed part. An evaluate before any advance sees the zero state.
    add_item(CMD_EVALUATE, 16'sh1234, -16'sd5, 16'sh7FFF, 16'h4000, 0, 0);
    // First advance after reset uses a zero start slope.
    add_item(CMD_ADVANCE, 16'sd100, 16'sd200, 16'sd300, 16'hFFFF, 0, 0);
    add_item(CMD_EVALUATE, '0, '0, '0, 16'h0000, 0, 0);
    // The low position bit is dropped, so this matches position zero.
    add_item(CMD_EVALUATE, '0, '0, '0, 16'h0001, 0, 0);
    add_item(CMD_EVALUATE, '0, '0, '0, 16'hFFFF, 0, 0);
    add_item(CMD_EVALUATE, '0, '0, '0, 16'h8000, 0, 0);
    // Alternating full-scale samples drive the step across a segment to its extremes.
    add_item(CMD_ADVANCE, 16'sh7FFF, 16'sh8000, 16'sh7FFF, 16'h0000, 0, 0);
    add_item(CMD_EVALUATE, '0, '0, '0, 16'h8000, 0, 0);
    add_item(CMD_EVALUATE, '0, '0, '0, 16'hC000, 0, 0);
    add_item(CMD_EVALUATE, '0, '0, '0, 16'hFFFE, 0, 0);
    add_item(CMD_ADVANCE, 16'sh8000, 16'sh7FFF, 16'sh8000, 16'hFFFF, 0, 0);
    add_item(CMD_EVALUATE, '0, '0, '0, 16'h5555, 0, 0);
    add_item(CMD_EVALUATE, '0, '0, '0, 16'hAAAB, 0, 0);
    add_item(CMD_ADVANCE, 16'sh7FFF, 16'sh8000, 16'sh7FFF, 16'h0000, 0, 0);
    add_item(CMD_EVALUATE, '0, '0, '0, 16'h6000, 0, 0);
    add_item(CMD_EVALUATE, '0, '0, '0, 16'h2000, 0, 0);
    add_item(CMD_ADVANCE, 16'sh0000, 16'sh0000, 16'sh0000, 16'h0000, 0, 0);
    add_item(CMD_EVALUATE, 16'sh7FFF, 16'sh8000, 16'sh7FFF, 16'h7FFF, 0, 0);
    add_item(CMD_ADVANCE, -16'sd1, -16'sd1, -16'sd1, 16'h0000, 0, 0);
    add_item(CMD_EVALUATE, '0, '0, '0, 16'hFFFF, 0, 0);

    // Random part in four idling phases: none, sender, receiver, both.
    for (ph = 0; ph < 4; ph++) begin
      tx  = (ph == 1) ? 57 : (ph == 3) ? 25 : 0;
      rx  = (ph == 2) ? 57 : (ph == 3) ? 25 : 0;
      cnt = 0;
      while (cnt < PHASE_ITEMS) begin
        if ($urandom_range(99) < 85) begin
          // A new segment followed by a few evaluations inside it.
          add_item(CMD_ADVANCE, rand_sample(), rand_sample(), rand_sample(),
                   POS_W'($urandom), tx, rx);
          nev = $urandom_range(4, 1);
          for (k = 0; k < nev; k++) begin
            add_item(CMD_EVALUATE, SAMPLE_W'($urandom), SAMPLE_W'($urandom),
                     SAMPLE_W'($urandom), rand_pos(), tx, rx);
          end
          cnt += nev + 1;
        end else begin
          // Noise: any command with arbitrary fields.
          add_item(1'($urandom), SAMPLE_W'($urandom), SAMPLE_W'($urandom),
                   SAMPLE_W'($urandom), POS_W'($urandom), tx, rx);
          cnt++;
        end
      end
    end

    repeat (5) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // Wait for all items to be taken and all results to arrive, then drain.
    @(posedge clk);
    while (pending_items.size() != 0 || in_valid) @(posedge clk);
    while (expected_values.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (expected_values.size() != 0) begin
      n_errors++;
    end
    $display("Sent %0d advance and %0d evaluate items over four idling phases;",
             n_advances, n_evaluates);
    $display("checked %0d interpolated values, %0d errors.", n_checked, n_errors);
    if (n_errors == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule

// File: cubic_spline_sample_interpolator.f
hw/rtl/csi_pkg.sv
hw/rtl/csi_coef.sv
hw/rtl/csi_mac.sv
hw/rtl/csi_round.sv
hw/rtl/cubic_spline_sample_interpolator.sv
verif/tb_cubic_spline_sample_interpolator.sv
